>>> rtl/sem_pkg.sv
// Shared types, constants and control structs of the Sobel edge magnitude block.
package sem_pkg;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Register fields
  localparam int LW_W = 11;
  localparam int FH_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam logic [LW_W-1:0] LW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // Register indexes
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Gradient energy: 2 * 1020^2 fits in 21 bits
  localparam int ENERGY_W = 21;
  localparam logic [7:0] MAG_TOP_BIT = 8'd128;

  typedef logic [23:0] pix_t;
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_GRAD,
    ST_ROOT,
    ST_LOAD
  } sem_state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic grad;
    logic root_step;
    logic load;
  } sem_cmd_t;

  typedef struct packed {
    logic ignore;
    logic emit;
    logic root_last;
    logic out_free;
  } sem_sts_t;

endpackage

>>> rtl/sem_ctrl.sv
// Controller state machine sequencing one item through the datapath.
module sem_ctrl import sem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sem_sts_t sts,
  output sem_cmd_t cmd
);

  sem_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = rst_n;
        cmd.accept = in_valid && rst_n;
        if (cmd.accept && !sts.ignore) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.emit ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/sem_dpath.sv
// Datapath: row stores, 3x3 window, counters, gradient, square root, output register.
module sem_dpath import sem_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  output out_item_t             out_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  sem_cmd_t              cmd,
  output sem_sts_t              sts
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WE_W  = $clog2(MAX_WIDTH + 1);
  localparam int HE_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  function automatic win_t shift_col(win_t w, pix_t t, pix_t m, pix_t b);
    win_t o;
    o[0] = w[1]; o[1] = w[2]; o[2] = t;
    o[3] = w[4]; o[4] = w[5]; o[5] = m;
    o[6] = w[7]; o[7] = w[8]; o[8] = b;
    return o;
  endfunction

  logic [LW_W-1:0]  lw_r;
  logic [FH_W-1:0]  fh_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  win_t             win_r;
  pix_t             s_r, rd_upper_r, rd_mid_r;
  win_t             ew_r;
  logic             fe_r;
  logic [ENERGY_W-1:0] energy_r [3];
  logic [7:0]       root_r [3];
  logic [2:0]       bit_r;
  out_item_t        out_r;
  logic             out_valid_r;

  pix_t upper_mem [MAX_WIDTH];
  pix_t mid_mem   [MAX_WIDTH];

  logic [WE_W-1:0] w_eff;
  logic [HE_W-1:0] h_eff;
  logic            in_frame, first_col, close_row, frame_done, main_emit, last_col;
  pix_t            top_px, mid_px;
  win_t            w_close, w_main;
  logic [ENERGY_W-1:0] energy_nxt [3];
  logic [7:0]      root_nxt [3];

  // Effective frame size
  always_comb begin
    if (lw_r == '0) begin
      w_eff = WE_W'(1);
    end else if (32'(lw_r) > MAX_WIDTH) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(lw_r);
    end
    if (fh_r == '0) begin
      h_eff = HE_W'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h_eff = HE_W'(MAX_HEIGHT);
    end else begin
      h_eff = HE_W'(fh_r);
    end
  end

  // Position decode
  always_comb begin
    in_frame   = 32'(row_r) < 32'(h_eff);
    first_col  = col_r == '0;
    close_row  = first_col && (32'(row_r) >= 32'd2);
    frame_done = first_col && (32'(row_r) == 32'(h_eff) + 32'd1);
    main_emit  = !first_col && (row_r != '0);
    last_col   = 32'(col_r) + 32'd1 >= 32'(w_eff);
    top_px     = (32'(row_r) >= 32'd2) ? rd_upper_r : '0;
    mid_px     = (row_r != '0) ? rd_mid_r : '0;
    w_close    = shift_col(win_r, '0, '0, '0);
    w_main     = shift_col(first_col ? win_t'('0) : win_r, top_px, mid_px, s_r);
  end

  always_comb begin
    sts.ignore    = in_frame && in_data.action;
    sts.emit      = close_row || main_emit;
    sts.root_last = bit_r == '0;
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Row stores: read on transfer, write back on update
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_upper_r <= upper_mem[col_r];
      rd_mid_r   <= mid_mem[col_r];
    end
    if (cmd.update && !frame_done) begin
      upper_mem[col_r] <= rd_mid_r;
      mid_mem[col_r]   <= s_r;
    end
  end

  // Configuration, counters and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r  <= LW_RESET;
      fh_r  <= FH_RESET;
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_LINE_WIDTH) begin
        lw_r <= cfg_wdata[LW_W-1:0];
      end else begin
        fh_r <= cfg_wdata[FH_W-1:0];
      end
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
    end else if (cmd.update) begin
      if (frame_done) begin
        col_r <= '0;
        row_r <= '0;
        win_r <= '0;
      end else begin
        win_r <= w_main;
        if (last_col) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  // Latch pixel and emission window
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r <= in_frame ? {in_data.in_red, in_data.in_green, in_data.in_blue} : '0;
    end
    if (cmd.update) begin
      ew_r <= close_row ? w_close : w_main;
      fe_r <= frame_done;
    end
  end

  // Gradient energy per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [11:0] p [9];
      logic signed [11:0] gx, gy;
      logic signed [23:0] sx, sy;
      for (int i = 0; i < 9; i++) begin
        p[i] = $signed({4'b0, ew_r[i][16-8*k +: 8]});
      end
      gx = (p[2] - p[0]) + 12'sd2 * (p[5] - p[3]) + (p[8] - p[6]);
      gy = (p[6] - p[0]) + 12'sd2 * (p[7] - p[1]) + (p[8] - p[2]);
      sx = gx * gx;
      sy = gy * gy;
      energy_nxt[k] = ENERGY_W'(sx) + ENERGY_W'(sy);
    end
  end

  // One bit of the rounded root per step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [7:0]  t;
      logic [15:0] tt;
      t  = root_r[k] | (MAG_TOP_BIT >> (3'd7 - bit_r));
      tt = 16'(t) * 16'(t) - 16'(t);
      root_nxt[k] = (ENERGY_W'(tt) < energy_r[k]) ? t : root_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      for (int k = 0; k < 3; k++) begin
        energy_r[k] <= energy_nxt[k];
        root_r[k]   <= '0;
      end
    end else if (cmd.root_step) begin
      for (int k = 0; k < 3; k++) begin
        root_r[k] <= root_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 3'd7;
    end else if (cmd.grad) begin
      bit_r <= 3'd7;
    end else if (cmd.root_step) begin
      bit_r <= bit_r - 3'd1;
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.out_red   <= root_r[0];
      out_r.out_green <= root_r[1];
      out_r.out_blue  <= root_r[2];
      out_r.frame_end <= fe_r;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/sobel_edge_magnitude_rgb.sv
// Top level of the Sobel edge magnitude block over an RGB pixel stream.
//
//  channel | ports                          | role
//  --------+--------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data    | pixel or drain item
//  result  | out_valid, out_ready, out_data | gradient magnitudes, frame end
//  config  | cfg_we, cfg_addr, cfg_wdata    | line width, frame height
//
// An item that gives no result passes through the transfer, then row store
// read-back and window update; an item that gives a result goes on to
// the gradient energy, the bit-serial root one bit per step, and the
// load of the output register.
// A drain item inside the frame is dropped at its transfer.
// Reset is synchronous; the row stores are not cleared.
// A stalled result waits in the output register; the next item is
// accepted meanwhile and waits only if its own result is ready before the
// register frees up.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  sem_cmd_t cmd;
  sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sem_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // Window update follows a transfer
  a_update_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> $past(cmd.accept))
    else $error("update without a preceding transfer");

  // No transfer while an item is in work
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update || cmd.grad || cmd.root_step) |-> !in_ready)
    else $error("input ready while busy");

endmodule
